>>> design/rgb_palette_indexer_core_macros.svh
// Assertion macros for the checker file of the palette indexer.
`ifndef RGB_PALETTE_INDEXER_CORE_MACROS_SVH
`define RGB_PALETTE_INDEXER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rpi_pkg.sv
package rpi_pkg;

	localparam int PAL_DEPTH = 4096;
	localparam int IDX_W     = 12;
	localparam int CNT_W     = 13;

	typedef logic [23:0] rgb_t;

	localparam logic [1:0] OPC_INDEX = 2'd0;
	localparam logic [1:0] OPC_READ  = 2'd1;
	localparam logic [1:0] OPC_CLEAR = 2'd2;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

endpackage

>>> design/rgb_palette_indexer_core.sv
// Palette indexer: each beat taken on start (while busy is low) gives exactly one result,
// shown for a single cycle with strobe high; the receiver cannot stall, so results must be
// captured when they appear. An index beat walks the palette memory with one comparator,
// one entry per cycle from entry 0, until the colour is found or all filled entries are
// passed; busy is high throughout. A read beat holds busy through S_READ1 and S_READ2 for
// the registered memory read; its result is registered in S_READ2. Clear and the unused
// opcode answer in the cycle after acceptance without raising busy. The palette needs no
// clearing pass: a fill count marks which entries are valid.
module rgb_palette_indexer_core import rpi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       opcode,
	input  logic [7:0]       pixel_red,
	input  logic [7:0]       pixel_green,
	input  logic [7:0]       pixel_blue,
	input  logic [IDX_W-1:0] entry_select,
	input  logic             last_pixel,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] color_index,
	output logic [7:0]       entry_red,
	output logic [7:0]       entry_green,
	output logic [7:0]       entry_blue,
	output logic [CNT_W-1:0] distinct_count,
	output logic             image_done
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_READ1  = 2'd2;
	localparam logic [1:0] S_READ2  = 2'd3;

	rgb_t mem [PAL_DEPTH];

	logic [1:0]       state_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] ptr_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] cmp_idx_q;
	rgb_t             rd_data_q;
	rgb_t             color_q;
	logic [IDX_W-1:0] sel_q;
	logic             last_q;

	logic             strobe_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] index_q;
	rgb_t             entry_q;
	logic [CNT_W-1:0] count_q;
	logic             done_q;

	logic             accept;
	logic [IDX_W-1:0] rd_addr;
	logic             hit;
	logic             miss;
	logic             sel_valid;

	assign accept    = start && (state_q == S_IDLE);
	assign rd_addr   = (state_q == S_READ1) ? sel_q : ptr_q[IDX_W-1:0];
	assign hit       = cmp_vld_q && (rd_data_q == color_q);
	assign miss      = !cmp_vld_q && (ptr_q >= used_q);
	assign sel_valid = {1'b0, sel_q} < used_q;

	// The memory holds no reset; only entries below the fill count are ever looked at.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (state_q == S_SEARCH && !hit && miss && used_q != CNT_W'(PAL_DEPTH)) begin
			mem[used_q[IDX_W-1:0]] <= color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			cmp_vld_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						color_q   <= {pixel_red, pixel_green, pixel_blue};
						sel_q     <= entry_select;
						last_q    <= last_pixel;
						ptr_q     <= '0;
						cmp_vld_q <= 1'b0;
						case (opcode)
							OPC_INDEX: state_q <= S_SEARCH;
							OPC_READ:  state_q <= S_READ1;
							OPC_CLEAR: begin
								used_q   <= '0;
								strobe_q <= 1'b1;
								status_q <= ST_FOUND;
								index_q  <= '0;
								entry_q  <= '0;
								count_q  <= '0;
								done_q   <= last_pixel;
							end
							default: begin
								strobe_q <= 1'b1;
								status_q <= ST_FOUND;
								index_q  <= '0;
								entry_q  <= '0;
								count_q  <= used_q;
								done_q   <= last_pixel;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						strobe_q <= 1'b1;
						status_q <= ST_FOUND;
						index_q  <= cmp_idx_q;
						entry_q  <= '0;
						count_q  <= used_q;
						done_q   <= last_q;
						state_q  <= S_IDLE;
					end else if (miss) begin
						strobe_q <= 1'b1;
						entry_q  <= '0;
						done_q   <= last_q;
						state_q  <= S_IDLE;
						if (used_q == CNT_W'(PAL_DEPTH)) begin
							status_q <= ST_FULL;
							index_q  <= '0;
							count_q  <= used_q;
						end else begin
							status_q <= ST_ADDED;
							index_q  <= used_q[IDX_W-1:0];
							count_q  <= used_q + 1'b1;
							used_q   <= used_q + 1'b1;
						end
					end else if (ptr_q < used_q) begin
						// The read issued now is compared in the next cycle.
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= ptr_q[IDX_W-1:0];
						ptr_q     <= ptr_q + 1'b1;
					end else begin
						cmp_vld_q <= 1'b0;
					end
				end
				S_READ1: begin
					state_q <= S_READ2;
				end
				S_READ2: begin
					strobe_q <= 1'b1;
					status_q <= ST_READ;
					index_q  <= sel_q;
					entry_q  <= sel_valid ? rd_data_q : '0;
					count_q  <= used_q;
					done_q   <= last_q;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign strobe         = strobe_q;
	assign status         = status_q;
	assign color_index    = index_q;
	assign entry_red      = entry_q[23:16];
	assign entry_green    = entry_q[15:8];
	assign entry_blue     = entry_q[7:0];
	assign distinct_count = count_q;
	assign image_done     = done_q;

endmodule

>>> design/rpi_checker.sv
`include "rgb_palette_indexer_core_macros.svh"

module rpi_checker import rpi_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             strobe,
	input logic [1:0]       status,
	input logic [IDX_W-1:0] color_index,
	input logic [7:0]       entry_red,
	input logic [7:0]       entry_green,
	input logic [7:0]       entry_blue,
	input logic [CNT_W-1:0] distinct_count
);

	// An accepted beat either answers at once or holds the block busy.
	`RPI_ASSERT_NEXT(a_accept_busy_or_result, start && !busy, busy || strobe, "beat accepted but neither busy nor result")
	// Leaving busy always coincides with a result.
	`RPI_ASSERT_SAME(a_busy_end_result, $fell(busy), strobe, "busy dropped without a result")
	// A newly added colour sits at the last filled entry.
	`RPI_ASSERT_SAME(a_added_count, strobe && status == ST_ADDED, distinct_count == {1'b0, color_index} + 1'b1, "added index does not match count")
	// Only read results carry colour data.
	`RPI_ASSERT_SAME(a_entry_zero, strobe && status != ST_READ, entry_red == 8'd0 && entry_green == 8'd0 && entry_blue == 8'd0, "entry colour on a non-read result")

endmodule

bind rgb_palette_indexer_core rpi_checker u_rpi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.strobe         (strobe),
	.status         (status),
	.color_index    (color_index),
	.entry_red      (entry_red),
	.entry_green    (entry_green),
	.entry_blue     (entry_blue),
	.distinct_count (distinct_count)
);
